// ----- rtl/core/hbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_pkg: shared types and constants of the hashed block cache tag store
// Entry record, command and status codes, bucket arithmetic.
// ----------------------------------------------------------------------------
package hbc_pkg;
  localparam int NumEntries = 32;
  localparam int NumBuckets = 13;
  localparam int IdxW = $clog2(NumEntries);
  localparam int BktW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int ByteMod = 256 % NumBuckets;
  localparam int RedSteps = $clog2(NumBuckets + (256 + NumBuckets - 1) / NumBuckets + 1);

  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PIN     = 2'd2;
  localparam logic [1:0] CMD_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;
  localparam logic [1:0] ST_OVER   = 2'd3;

  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [BktW-1:0] bkt;
    logic [7:0]  cnt;
    logic [31:0] rtime;
    logic        valid;
  } entry_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    entry_t          ent;
  } slot_t;

  // One byte step of the bucket: (r*256 + b) mod N. The factor 256 is folded
  // to 256 mod N, and the remainder is left after subtracting shifted copies
  // of N from the largest down.
  function automatic logic [BktW-1:0] bucket_step(input logic [BktW-1:0] r,
                                                  input logic [7:0] b);
    logic [15:0] x;
    x = 16'(r) * 16'(ByteMod) + 16'(b);
    for (int k = RedSteps - 1; k >= 0; k--) begin
      if (x >= 16'(NumBuckets << k)) x = x - 16'(NumBuckets << k);
    end
    return BktW'(x);
  endfunction

  // Bucket held by entry e after reset.
  function automatic logic [31:0] reset_block(input int e);
    int acc;
    int cnt;
    acc = 0;
    for (int b = 0; b < NumBuckets; b++) begin
      cnt = NumEntries / NumBuckets + ((b < NumEntries % NumBuckets) ? 1 : 0);
      if (e >= acc && e < acc + cnt) return 32'(b);
      acc = acc + cnt;
    end
    return 32'd0;
  endfunction
endpackage

// ----- rtl/core/hbc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_req_if / hbc_rsp_if: request and response channels
// Valid/ready handshake carrying one item.
// ----------------------------------------------------------------------------
interface hbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  device_id;
  logic [31:0] block_number;
  logic [4:0]  entry_index;
  logic [31:0] now_tick;
  modport source (output valid, command, device_id, block_number, entry_index, now_tick,
                  input ready);
  modport sink (input valid, command, device_id, block_number, entry_index, now_tick,
                output ready);
endinterface

interface hbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] granted_entry;
  logic       was_hit;
  logic       needs_read;
  logic [1:0] status;
  modport source (output valid, granted_entry, was_hit, needs_read, status, input ready);
  modport sink (input valid, granted_entry, was_hit, needs_read, status, output ready);
endinterface

// ----- rtl/core/hbc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_cell: one entry slot of the rotating ring
// Passes its slot on to the next cell every cycle while the ring turns,
// or takes the write-back slot when the ring loads.
// ----------------------------------------------------------------------------
module hbc_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  hbc_pkg::slot_t rst_val,
  input  hbc_pkg::slot_t prev,
  input  logic          wr,
  input  hbc_pkg::slot_t wr_val,
  output hbc_pkg::slot_t cur
);
  import hbc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= rst_val;
    end else if (wr) begin
      cur <= wr_val;
    end else if (shift) begin
      cur <= prev;
    end
  end
endmodule

// ----- rtl/core/hashed_block_cache_tag_lru.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_cache_tag_lru: tag store of a disk block buffer cache
// Entries sit in a ring of cells; the head cell is inspected each cycle of the scan.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   req      in         command, device_id, block_number, entry_index, now_tick
//   rsp      out        granted_entry, was_hit, needs_read, status
//
// A new item is accepted only after the last one leaves the output state. The
// block number is folded into its bucket a byte at a time, a turn of the ring
// scans for a match and both victims, then the decide, update and output
// states pick the target, form the entry and load the result. Reset loads the
// initial tags. The result register lets the next item start while a result
// waits; a second finished result holds in S_OUT until the first is taken.
module hashed_block_cache_tag_lru (
  input logic clk,
  input logic rst,
  hbc_req_if.sink   req,
  hbc_rsp_if.source rsp
);
  import hbc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BKT  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam int CntW = $clog2(NumEntries + 1);

  logic [2:0] state;
  logic [CntW-1:0] cnt;
  logic [1:0]  cmd;
  logic [7:0]  dev;
  logic [31:0] blk;
  logic [4:0]  idx;
  logic [31:0] now;
  logic [BktW-1:0] bkt;
  logic [7:0]  blk_byte;
  logic hit_f, bv_f, av_f;
  logic [IdxW-1:0] hit_i, bv_i, av_i, tgt;
  logic [31:0] bv_t, av_t;
  logic [1:0] st;
  logic did_hit, need;
  slot_t wslot;
  logic  wr_en;
  slot_t wslot_next;
  logic  wr_next, hit_next, need_next;
  logic [1:0] st_next;
  logic  out_load;

  slot_t ring [NumEntries];
  slot_t rvals [NumEntries];
  logic shift;
  slot_t head;

  assign shift = (state == S_SCAN);
  assign head  = ring[0];

  for (genvar g = 0; g < NumEntries; g++) begin : g_ring
    logic wr_here;
    assign rvals[g].idx       = IdxW'(g);
    assign rvals[g].ent.dev   = '0;
    assign rvals[g].ent.blk   = reset_block(g);
    assign rvals[g].ent.bkt   = BktW'(reset_block(g));
    assign rvals[g].ent.cnt   = '0;
    assign rvals[g].ent.rtime = '0;
    assign rvals[g].ent.valid = 1'b0;
    assign wr_here = wr_en && (ring[g].idx == wslot.idx);
    hbc_cell u_cell (
      .clk(clk), .rst(rst), .shift(shift), .rst_val(rvals[g]),
      .prev(ring[(g + 1) % NumEntries]), .wr(wr_here), .wr_val(wslot), .cur(ring[g])
    );
  end

  // Entry selected for update: found by index after the turn.
  slot_t tslot;
  always_comb begin
    tslot = ring[0];
    for (int k = 0; k < NumEntries; k++) begin
      if (ring[k].idx == tgt) tslot = ring[k];
    end
  end

  // The bucket is folded in from the most significant byte down.
  always_comb begin
    case (cnt[1:0])
      2'd0: blk_byte = blk[31:24];
      2'd1: blk_byte = blk[23:16];
      2'd2: blk_byte = blk[15:8];
      default: blk_byte = blk[7:0];
    endcase
  end

  always_comb begin
    wslot_next = tslot;
    wr_next = 1'b0;
    hit_next = 1'b0;
    need_next = 1'b0;
    st_next = ST_OK;
    case (cmd)
      CMD_LOOKUP: begin
        if (hit_f) begin
          hit_next = 1'b1;
          need_next = !tslot.ent.valid;
          wslot_next.ent.valid = 1'b1;
          wr_next = 1'b1;
          if (tslot.ent.cnt == 8'hFF) st_next = ST_OVER;
          else wslot_next.ent.cnt = tslot.ent.cnt + 8'd1;
        end else if (bv_f || av_f) begin
          need_next = 1'b1;
          wslot_next.ent.dev = dev;
          wslot_next.ent.blk = blk;
          wslot_next.ent.bkt = bkt;
          wslot_next.ent.cnt = 8'd1;
          wslot_next.ent.valid = 1'b1;
          wr_next = 1'b1;
        end else begin
          st_next = ST_NOFREE;
        end
      end
      CMD_PIN: begin
        if (32'(idx) < NumEntries) begin
          if (tslot.ent.cnt == 8'hFF) st_next = ST_OVER;
          else begin
            wslot_next.ent.cnt = tslot.ent.cnt + 8'd1;
            wr_next = 1'b1;
          end
        end
      end
      default: begin
        if (32'(idx) < NumEntries) begin
          if (tslot.ent.cnt == 8'd0) st_next = ST_UNDER;
          else begin
            wslot_next.ent.cnt = tslot.ent.cnt - 8'd1;
            wr_next = 1'b1;
            if (cmd == CMD_RELEASE && tslot.ent.cnt == 8'd1)
              wslot_next.ent.rtime = now;
          end
        end
      end
    endcase
  end

  assign out_load  = (state == S_OUT) && (!rsp.valid || rsp.ready);
  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.valid <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      wr_en <= (state == S_UPD) && wr_next;
      if (out_load) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cmd <= req.command; dev <= req.device_id; blk <= req.block_number;
            idx <= req.entry_index; now <= req.now_tick;
            hit_f <= 1'b0; bv_f <= 1'b0; av_f <= 1'b0;
            cnt <= '0;
            bkt <= '0;
            state <= S_BKT;
          end
        end
        S_BKT: begin
          bkt <= bucket_step(bkt, blk_byte);
          if (cnt == CntW'(3)) begin
            cnt <= '0;
            state <= S_SCAN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SCAN: begin
          if (head.ent.dev == dev && head.ent.blk == blk &&
              (!hit_f || head.idx < hit_i)) begin
            hit_f <= 1'b1; hit_i <= head.idx;
          end
          if (head.ent.cnt == 8'd0) begin
            if (head.ent.bkt == bkt && (!bv_f || head.ent.rtime < bv_t ||
                (head.ent.rtime == bv_t && head.idx < bv_i))) begin
              bv_f <= 1'b1; bv_i <= head.idx; bv_t <= head.ent.rtime;
            end
            if (!av_f || head.ent.rtime < av_t ||
                (head.ent.rtime == av_t && head.idx < av_i)) begin
              av_f <= 1'b1; av_i <= head.idx; av_t <= head.ent.rtime;
            end
          end
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(NumEntries - 1)) state <= S_DEC;
        end
        S_DEC: begin
          if (cmd == CMD_LOOKUP) begin
            tgt <= hit_f ? hit_i : (bv_f ? bv_i : av_i);
          end else begin
            tgt <= IdxW'(idx);
          end
          state <= S_UPD;
        end
        S_UPD: begin
          wslot <= wslot_next;
          st <= st_next;
          did_hit <= hit_next;
          need <= need_next;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.was_hit    <= did_hit;
      rsp.needs_read <= need;
      rsp.status     <= st;
      if (cmd == CMD_LOOKUP) rsp.granted_entry <= (st == ST_NOFREE) ? 5'd0 : 5'(wslot.idx);
      else rsp.granted_entry <= idx;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.granted_entry) &&
    $stable(rsp.was_hit) && $stable(rsp.needs_read) && $stable(rsp.status))
    else $error("response changed while stalled");
  a_nofree_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_NOFREE |-> !rsp.was_hit && !rsp.needs_read)
    else $error("no-free result flags");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready) else $error("ready while busy");
  a_no_write_turning: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !shift) else $error("write while ring turns");
endmodule
